@@ design/krs_pkg.sv @@
`default_nettype none

package krs_pkg;

  // Field widths
  localparam int RANK_W  = 10;
  localparam int SIZE_W  = 11;
  localparam int RADIX_W = 4;
  localparam int LEVEL_W = 4;
  localparam int SLOT_W  = 5;
  localparam int DIST_W  = 13;
  localparam int CHILD_W = 3;
  localparam int VP_W    = 14;
  localparam int RECIP_W = 14;

  // Group and radix limits
  localparam logic [SIZE_W-1:0]  MAX_GROUP   = 11'd1024;
  localparam logic [RADIX_W-1:0] MIN_RADIX   = 4'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX   = 4'd8;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd4;

  // q / r == (q * recip(r)) >> RECIP_SHIFT, exact for q < 1024 and r <= 8
  localparam int RECIP_SHIFT = 14;

  typedef enum logic [1:0] {
    KIND_RECV = 2'd0,
    KIND_SEND = 2'd1,
    KIND_DONE = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_REM,
    ST_DECIDE,
    ST_RECV,
    ST_SEND,
    ST_NEXT,
    ST_DONE,
    ST_BAD
  } krs_state_t;

  // Controller to datapath
  typedef struct packed {
    logic  load;
    logic  setup;
    logic  div;
    logic  rem;
    logic  decide;
    logic  step;
    logic  next_lvl;
    logic  emit;
    kind_t kind;
  } krs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad;
    logic single;
    logic pos_zero;
    logic child_live;
    logic child_last;
    logic more;
    logic out_free;
  } krs_stat_t;

  // Scaled reciprocal, ceil(2^14 / r), for the clamped radix
  function automatic logic [RECIP_W-1:0] recip_of(input logic [RADIX_W-1:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      4'd2:    m = 14'd8192;
      4'd3:    m = 14'd5462;
      4'd4:    m = 14'd4096;
      4'd5:    m = 14'd3277;
      4'd6:    m = 14'd2731;
      4'd7:    m = 14'd2341;
      4'd8:    m = 14'd2048;
      default: m = 14'd8192;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ design/krs_ctrl.sv @@
`default_nettype none

module krs_ctrl
  import krs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  krs_stat_t stat,
  output krs_cmd_t  cmd
);

  krs_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = KIND_DONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.setup = 1'b1;
        if (stat.bad) begin
          state_nxt = ST_BAD;
        end else if (stat.single) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_REM;
      end
      ST_REM: begin
        cmd.rem   = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.pos_zero ? ST_RECV : ST_SEND;
      end
      ST_RECV: begin
        // children past the group end are skipped without an item
        if (!stat.child_live || stat.out_free) begin
          cmd.step  = 1'b1;
          cmd.emit  = stat.child_live;
          cmd.kind  = KIND_RECV;
          state_nxt = stat.child_last ? ST_NEXT : ST_RECV;
        end
      end
      ST_SEND: begin
        // after its send a member has nothing left to do
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_SEND;
          state_nxt = ST_DONE;
        end
      end
      ST_NEXT: begin
        cmd.next_lvl = 1'b1;
        state_nxt    = stat.more ? ST_DIV : ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_DONE;
          state_nxt = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_BAD;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/krs_dpath.sv @@
`default_nettype none

module krs_dpath
  import krs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [RADIX_W-1:0] cfg_wr_data,
  input  logic [RANK_W-1:0]  in_own_rank,
  input  logic [RANK_W-1:0]  in_root_rank,
  input  logic [SIZE_W-1:0]  in_group_size,
  input  krs_cmd_t           cmd,
  output krs_stat_t          stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [RANK_W-1:0]  out_peer,
  output logic [LEVEL_W-1:0] out_level,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_last
);

  logic [RADIX_W-1:0] radix_r;
  logic [RANK_W-1:0]  own_r, root_r;
  logic [SIZE_W-1:0]  size_r;
  logic [RADIX_W-1:0] r_r;
  logic [RANK_W-1:0]  vrank_r, q_r, qq_r;
  logic [CHILD_W-1:0] pos_r, c_r;
  logic [DIST_W-1:0]  d_r;
  logic [LEVEL_W-1:0] level_r;
  logic [VP_W-1:0]    vp_r;
  logic [SLOT_W-1:0]  slot_r;

  logic               out_valid_r;
  kind_t              out_kind_r, out_kind_nxt;
  logic [RANK_W-1:0]  out_peer_r, out_peer_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic               out_last_r, out_last_nxt;

  logic [RADIX_W-1:0]          radix_lim, r_nxt;
  logic [SIZE_W-1:0]           vrank_wide;
  logic [RANK_W+RECIP_W-1:0]   quo_prod;
  logic [RANK_W+RADIX_W-1:0]   rem_prod;
  logic [RANK_W-1:0]           pos_full;
  logic [RADIX_W-1:0]          r_m1;
  logic [CHILD_W-1:0]          k_sel;
  logic [CHILD_W+DIST_W-1:0]   kd_prod;
  logic [VP_W-1:0]             vp_nxt;
  logic [DIST_W+RADIX_W-1:0]   dr_prod;
  logic [VP_W:0]               peer_sum, peer_mod;

  // Radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  // Radix clamp: 2..MAX_RADIX, then group size
  always_comb begin
    if (radix_r < MIN_RADIX) begin
      radix_lim = MIN_RADIX;
    end else if (radix_r > MAX_RADIX) begin
      radix_lim = MAX_RADIX;
    end else begin
      radix_lim = radix_r;
    end
    if ({{(SIZE_W-RADIX_W){1'b0}}, radix_lim} > size_r) begin
      r_nxt = size_r[RADIX_W-1:0];
    end else begin
      r_nxt = radix_lim;
    end
  end

  // Re-base on the root, ranks already known below the size
  always_comb begin
    if (own_r >= root_r) begin
      vrank_wide = {1'b0, own_r} - {1'b0, root_r};
    end else begin
      vrank_wide = {1'b0, own_r} + size_r - {1'b0, root_r};
    end
  end

  // Digit extraction: quotient by reciprocal, then remainder
  assign quo_prod = q_r * recip_of(r_r);
  assign rem_prod = qq_r * r_r;
  assign pos_full = q_r - rem_prod[RANK_W-1:0];

  // Offset to the highest child or back to the parent
  assign r_m1    = r_r - 4'd1;
  assign k_sel   = (pos_r == '0) ? r_m1[CHILD_W-1:0] : pos_r;
  assign kd_prod = k_sel * d_r;
  assign vp_nxt  = (pos_r == '0)
                 ? {{(VP_W-RANK_W){1'b0}}, vrank_r} + kd_prod[VP_W-1:0]
                 : {{(VP_W-RANK_W){1'b0}}, vrank_r} - kd_prod[VP_W-1:0];

  assign dr_prod = d_r * r_r;

  // Virtual peer back to real rank
  always_comb begin
    peer_sum = {1'b0, vp_r} + {{(VP_W+1-RANK_W){1'b0}}, root_r};
    if (peer_sum >= {{(VP_W+1-SIZE_W){1'b0}}, size_r}) begin
      peer_mod = peer_sum - {{(VP_W+1-SIZE_W){1'b0}}, size_r};
    end else begin
      peer_mod = peer_sum;
    end
  end

  // Status
  always_comb begin
    stat.bad        = (size_r == '0) || (size_r > MAX_GROUP) ||
                      ({1'b0, own_r} >= size_r) || ({1'b0, root_r} >= size_r);
    stat.single     = (size_r == 11'd1);
    stat.pos_zero   = (pos_r == '0);
    stat.child_live = (vp_r < {{(VP_W-SIZE_W){1'b0}}, size_r});
    stat.child_last = (c_r == 3'd1);
    stat.more       = (dr_prod < {{(DIST_W+RADIX_W-SIZE_W){1'b0}}, size_r});
    stat.out_free   = !out_valid_r || out_ready;
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      own_r  <= in_own_rank;
      root_r <= in_root_rank;
      size_r <= in_group_size;
    end
    if (cmd.setup) begin
      r_r     <= r_nxt;
      vrank_r <= vrank_wide[RANK_W-1:0];
      q_r     <= vrank_wide[RANK_W-1:0];
      d_r     <= 13'd1;
      level_r <= '0;
    end
    if (cmd.div) begin
      qq_r <= quo_prod[RECIP_SHIFT +: RANK_W];
    end
    if (cmd.rem) begin
      pos_r <= pos_full[CHILD_W-1:0];
    end
    if (cmd.decide) begin
      vp_r   <= vp_nxt;
      c_r    <= r_m1[CHILD_W-1:0];
      slot_r <= '0;
      if (pos_r == '0) begin
        q_r <= qq_r;
      end
    end
    if (cmd.step) begin
      c_r  <= c_r - 3'd1;
      vp_r <= vp_r - {{(VP_W-DIST_W){1'b0}}, d_r};
      if (stat.child_live) begin
        slot_r <= slot_r + 5'd1;
      end
    end
    if (cmd.next_lvl) begin
      d_r     <= dr_prod[DIST_W-1:0];
      level_r <= level_r + 4'd1;
    end
  end

  // Result fields by kind
  always_comb begin
    out_kind_nxt  = cmd.kind;
    out_peer_nxt  = '0;
    out_level_nxt = '0;
    out_slot_nxt  = '0;
    out_last_nxt  = 1'b0;
    case (cmd.kind)
      KIND_RECV: begin
        out_peer_nxt  = peer_mod[RANK_W-1:0];
        out_level_nxt = level_r;
        out_slot_nxt  = slot_r;
      end
      KIND_SEND: begin
        out_peer_nxt  = peer_mod[RANK_W-1:0];
        out_level_nxt = level_r;
      end
      KIND_DONE: out_last_nxt = 1'b1;
      KIND_BAD:  out_last_nxt = 1'b1;
      default:   out_last_nxt = 1'b1;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r  <= out_kind_nxt;
      out_peer_r  <= out_peer_nxt;
      out_level_r <= out_level_nxt;
      out_slot_r  <= out_slot_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_peer  = out_peer_r;
  assign out_level = out_level_r;
  assign out_slot  = out_slot_r;
  assign out_last  = out_last_r;

`ifndef SYNTH
  // never overwrite an item that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("krs_dpath: item emitted over a pending item");

  // reciprocal quotient must leave a digit below the radix
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |-> (pos_r < r_r[CHILD_W:0]))
    else $error("krs_dpath: digit not below radix");

  // receive slots count at most r-1 children per level
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_RECV) |-> ({1'b0, out_slot_r} < {2'b0, r_r}))
    else $error("krs_dpath: receive slot out of range");

  // only done and bad input close a run
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == KIND_DONE || out_kind_r == KIND_BAD))
    else $error("krs_dpath: last flag on an event item");
`endif

endmodule

`default_nettype wire

@@ design/knomial_reduce_schedule.sv @@
`default_nettype none

// Channel | Handshake                 | Payload
// in      | in_valid / in_ready       | in_own_rank, in_root_rank, in_group_size
// out     | out_valid / out_ready     | out_kind, out_peer, out_level, out_slot, out_last
// cfg     | cfg_wr_en                 | cfg_wr_data (radix)
//
// One request at a time; in_ready is high only while the controller is idle.
// A request: load, check, levels, final item, plus output stalls. Receiving level:
// divide, remainder, decide, a step per child position, level step. Sending level:
// divide, remainder, decide, send, ending the walk. Bad or single-member input: no levels.
// Synchronous active-low reset; radix resets to 4.
// A full output register stalls the walk until out_ready frees it.

module knomial_reduce_schedule
  import krs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [RADIX_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RANK_W-1:0]  in_own_rank,
  input  logic [RANK_W-1:0]  in_root_rank,
  input  logic [SIZE_W-1:0]  in_group_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [RANK_W-1:0]  out_peer,
  output logic [LEVEL_W-1:0] out_level,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_last
);

  krs_cmd_t  cmd;
  krs_stat_t stat;

  // Sequencer
  krs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Walk arithmetic and result register
  krs_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_own_rank   (in_own_rank),
    .in_root_rank  (in_root_rank),
    .in_group_size (in_group_size),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_peer      (out_peer),
    .out_level     (out_level),
    .out_slot      (out_slot),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

@@ dv/sched_checker.sv @@
`timescale 1ns / 100ps

// Watches the request and schedule channels, predicts the schedule of every
// accepted request and compares each schedule item in order.
module sched_checker
  import krs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [RADIX_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [RANK_W-1:0]  in_own_rank,
  input  logic [RANK_W-1:0]  in_root_rank,
  input  logic [SIZE_W-1:0]  in_group_size,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_kind,
  input  logic [RANK_W-1:0]  out_peer,
  input  logic [LEVEL_W-1:0] out_level,
  input  logic [SLOT_W-1:0]  out_slot,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending_count,
  output int                 items_checked
);

  // Events kept per schedule; done follows unless the input is bad
  localparam int SCHED_MAX_EVENTS = 28;
  localparam int REPORT_LIMIT     = 10;

  typedef struct packed {
    kind_t               kind;
    logic [RANK_W-1:0]   peer;
    logic [LEVEL_W-1:0]  level;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } sched_item_t;

  sched_item_t        sched_q[$];
  sched_item_t        got;
  sched_item_t        want;
  logic [RADIX_W-1:0] radix_q;
  int                 miss_count = 0;
  int                 checked = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    items_checked = 0;
  end

  function automatic void add_item(input kind_t k, input int unsigned peer,
                                   input int unsigned lvl, input int unsigned slot,
                                   input logic last);
    sched_q.push_back('{k, RANK_W'(peer), LEVEL_W'(lvl), SLOT_W'(slot), last});
  endfunction

  // Full k-nomial reduce schedule for one request
  function automatic void plan_schedule(input logic [RANK_W-1:0] own,
                                        input logic [RANK_W-1:0] root,
                                        input logic [SIZE_W-1:0] size);
    int unsigned grp, rt, r, vr, top_d, d, lvl, pos, vpeer, n, slot_n;
    grp = size;
    rt  = root;
    if (grp == 0 || grp > MAX_GROUP || own >= size || root >= size) begin
      add_item(KIND_BAD, 0, 0, 0, 1'b1);
      return;
    end
    if (grp == 1) begin
      add_item(KIND_DONE, 0, 0, 0, 1'b1);
      return;
    end
    // clamp radix: floor, ceiling, then group size
    r = radix_q;
    if (r < MIN_RADIX) r = MIN_RADIX;
    if (r > MAX_RADIX) r = MAX_RADIX;
    if (r > grp) r = grp;
    // root becomes virtual rank 0
    vr = (own + grp - rt) % grp;
    top_d = 1;
    while (top_d * r < grp) top_d = top_d * r;
    d   = 1;
    lvl = 0;
    n   = 0;
    while (d <= top_d) begin
      slot_n = 0;
      if (vr % d == 0) begin
        pos = (vr / d) % r;
        if (pos == 0) begin
          // receive from children, highest first
          for (int unsigned c = r - 1; c >= 1; c--) begin
            vpeer = vr + c * d;
            if (vpeer < grp) begin
              if (n < SCHED_MAX_EVENTS) begin
                add_item(KIND_RECV, (vpeer + rt) % grp, lvl, slot_n, 1'b0);
                n++;
              end
              slot_n++;
            end
          end
        end else begin
          if (n < SCHED_MAX_EVENTS) begin
            add_item(KIND_SEND, (vr - pos * d + rt) % grp, lvl, 0, 1'b0);
            n++;
          end
        end
      end
      d = d * r;
      lvl++;
    end
    add_item(KIND_DONE, 0, 0, 0, 1'b1);
  endfunction

  task automatic note_mismatch(input string what, input bit has_want,
                               input sched_item_t exp_item, input sched_item_t act_item);
    miss_count++;
    if (miss_count <= REPORT_LIMIT) begin
      if (has_want)
        $display("%0t: %s: expected kind %0d peer %0d level %0d slot %0d last %0d, got kind %0d peer %0d level %0d slot %0d last %0d",
                 $realtime, what, exp_item.kind, exp_item.peer, exp_item.level,
                 exp_item.slot, exp_item.last, act_item.kind, act_item.peer,
                 act_item.level, act_item.slot, act_item.last);
      else
        $display("%0t: %s: got kind %0d peer %0d level %0d slot %0d last %0d",
                 $realtime, what, act_item.kind, act_item.peer, act_item.level,
                 act_item.slot, act_item.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      radix_q = RADIX_RESET;
      sched_q.delete();
    end else begin
      if (cfg_wr_en) radix_q = cfg_wr_data;
      // new request: queue its whole schedule
      if (in_valid && in_ready) plan_schedule(in_own_rank, in_root_rank, in_group_size);
      // schedule item leaving the block
      if (out_valid && out_ready) begin
        got = '{kind_t'(out_kind), out_peer, out_level, out_slot, out_last};
        checked++;
        if (sched_q.size() == 0) begin
          note_mismatch("schedule item with nothing expected", 1'b0, got, got);
        end else begin
          want = sched_q.pop_front();
          if (got.kind !== want.kind || got.peer !== want.peer ||
              got.level !== want.level || got.slot !== want.slot ||
              got.last !== want.last)
            note_mismatch("schedule item mismatch", 1'b1, want, got);
        end
      end
    end
    fail_count    <= miss_count;
    pending_count <= sched_q.size();
    items_checked <= checked;
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import krs_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int LONG_HOLD     = 600;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [RADIX_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [RANK_W-1:0]  in_own_rank = '0;
  logic [RANK_W-1:0]  in_root_rank = '0;
  logic [SIZE_W-1:0]  in_group_size = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_kind;
  logic [RANK_W-1:0]  out_peer;
  logic [LEVEL_W-1:0] out_level;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_last;

  int fail_count;
  int pending_count;
  int items_checked;
  int requests_sent = 0;
  int radix_writes = 0;
  int idle_cycles = 0;
  bit idle_on = 1'b1;
  bit rx_long_hold = 1'b0;

  logic [RADIX_W-1:0] phase_radix [PHASES] = '{4'd3, 4'd15, 4'd5, 4'd0, 4'd6,
                                               4'd7, 4'd2, 4'd8, 4'd1, 4'd4};

  always #5 clk = ~clk;

  knomial_reduce_schedule dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_own_rank  (in_own_rank),
    .in_root_rank (in_root_rank),
    .in_group_size(in_group_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_peer     (out_peer),
    .out_level    (out_level),
    .out_slot     (out_slot),
    .out_last     (out_last)
  );

  sched_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_own_rank  (in_own_rank),
    .in_root_rank (in_root_rank),
    .in_group_size(in_group_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_peer     (out_peer),
    .out_level    (out_level),
    .out_slot     (out_slot),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .items_checked(items_checked)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  // Schedule receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (rx_long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("knomial_reduce_schedule test failed");
      $finish;
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(input logic [RANK_W-1:0] own, input logic [RANK_W-1:0] root,
                              input logic [SIZE_W-1:0] size);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_own_rank   <= own;
    in_root_rank  <= root;
    in_group_size <= size;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // Stop offering and wait for every expected schedule item
  task automatic drain_schedules();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] value);
    drain_schedules();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radix_writes++;
  endtask

  // Mostly valid requests; some raw noise and some rank just past the group
  task automatic random_request();
    logic [SIZE_W-1:0] size;
    logic [RANK_W-1:0] own;
    logic [RANK_W-1:0] root;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      size = SIZE_W'($urandom);
      own  = RANK_W'($urandom);
      root = RANK_W'($urandom);
    end else if (pick == 2) begin
      size = SIZE_W'($urandom_range(1, 1023));
      own  = RANK_W'(size);
      root = RANK_W'($urandom_range(0, size - 1));
    end else begin
      if (pick < 7)       size = MAX_GROUP;
      else if (pick < 13) size = SIZE_W'($urandom_range(2, 16));
      else if (pick == 13) size = SIZE_W'(1);
      else                size = SIZE_W'($urandom_range(2, 1024));
      own  = RANK_W'($urandom_range(0, size - 1));
      root = (pick % 5 == 0) ? own : RANK_W'($urandom_range(0, size - 1));
    end
    send_request(own, root, size);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset radix, bad inputs, single member, extremes
    send_request(10'd0, 10'd0, 11'd1);
    send_request(10'd0, 10'd0, 11'd0);
    send_request(10'd0, 10'd0, 11'd1025);
    send_request(10'd1023, 10'd1023, 11'd2047);
    send_request(10'd5, 10'd0, 11'd5);
    send_request(10'd0, 10'd1023, 11'd1000);
    send_request(10'd0, 10'd0, 11'd1024);
    send_request(10'd1023, 10'd1023, 11'd1024);
    send_request(10'd1023, 10'd0, 11'd1024);
    send_request(10'd0, 10'd1023, 11'd1024);
    send_request(10'd1, 10'd0, 11'd2);
    send_request(10'd0, 10'd1, 11'd2);
    send_request(10'd2, 10'd1, 11'd3);
    send_request(10'd682, 10'd341, 11'd1024);
    // radix at and beyond its limits
    set_radix(4'd2);
    send_request(10'd0, 10'd0, 11'd1024);
    send_request(10'd511, 10'd0, 11'd1024);
    set_radix(4'd0);
    send_request(10'd0, 10'd0, 11'd1024);
    set_radix(4'd1);
    send_request(10'd5, 10'd9, 11'd10);
    set_radix(4'd8);
    send_request(10'd0, 10'd0, 11'd1024);
    send_request(10'd7, 10'd0, 11'd8);
    set_radix(4'd15);
    send_request(10'd0, 10'd512, 11'd1024);
    send_request(10'd1000, 10'd3, 11'd1024);
    set_radix(4'd9);
    send_request(10'd0, 10'd0, 11'd9);

    // random phases, one radix each; some without idling, one long hold-off
    for (int p = 0; p < PHASES; p++) begin
      set_radix(phase_radix[p]);
      idle_on = (p % 3 != 2);
      if (p == 3) rx_long_hold = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) random_request();
    end
    drain_schedules();

    $display("covered %0d requests (bad input, single member, full groups) over %0d radix writes",
             requests_sent, radix_writes);
    $display("compared %0d schedule items", items_checked);
    if (fail_count == 0)
      $display("knomial_reduce_schedule test passed");
    else
      $display("knomial_reduce_schedule test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/krs_pkg.sv
design/krs_ctrl.sv
design/krs_dpath.sv
design/knomial_reduce_schedule.sv
dv/sched_checker.sv
dv/tb.sv
